>>> sv/ssba_pkg.sv
`default_nettype none

package ssba_pkg;

  localparam int SLOT_W     = 12;
  localparam int OFFS_W     = 24;
  localparam int WORD_BITS  = 64;
  localparam int BIT_IDX_W  = 6;
  localparam int WORD_IDX_W = SLOT_W - BIT_IDX_W;
  localparam int MAP_SLOTS  = 2 ** SLOT_W;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_LOCATE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_BADID = 2'd2;

  localparam logic REG_SLOT_LIMIT   = 1'b0;
  localparam logic REG_SEARCH_START = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST   = 12'd4095;
  localparam logic [SLOT_W-1:0] SEARCH_START_RST = 12'd1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot_id;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [OFFS_W-1:0] byte_offset;
  } rsp_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_limit;
    logic [SLOT_W-1:0] search_start;
  } cfg_t;

  // bits of a map word whose slot number is at least bound
  function automatic logic [WORD_BITS-1:0] ge_mask(logic [WORD_IDX_W-1:0] word_idx,
                                                  logic [SLOT_W-1:0] bound);
    logic [WORD_BITS-1:0] m;
    m = '0;
    if (word_idx > bound[SLOT_W-1:BIT_IDX_W]) begin
      m = '1;
    end else if (word_idx == bound[SLOT_W-1:BIT_IDX_W]) begin
      m = {WORD_BITS{1'b1}} << bound[BIT_IDX_W-1:0];
    end
    return m;
  endfunction

  // lowest set bit: {found, index}
  function automatic logic [BIT_IDX_W:0] first_set(logic [WORD_BITS-1:0] v);
    logic [7:0] any_b;
    logic [2:0] bsel;
    logic [2:0] isel;
    logic [7:0] grp;
    any_b = '0;
    bsel  = '0;
    isel  = '0;
    for (int i = 0; i < 8; i++) begin
      any_b[i] = |v[8*i +: 8];
    end
    for (int i = 7; i >= 0; i--) begin
      if (any_b[i]) begin
        bsel = 3'(i);
      end
    end
    grp = v[8*bsel +: 8];
    for (int i = 7; i >= 0; i--) begin
      if (grp[i]) begin
        isel = 3'(i);
      end
    end
    return {|any_b, bsel, isel};
  endfunction

endpackage

`default_nettype wire

>>> sv/swap_slot_bitmap_allocator_unit.sv
// channel    direction  handshake                 payload
// request    in         start high, busy low      req_i   (mode, slot_id)
// result     out        done_o for one cycle      rsp_o   (status, slot, byte_offset)
// config     in         psel/penable/pwrite       paddr, pwdata; prdata on reads
//
// one word at a time; locate goes straight from idle to the response state, free reads,
// modifies and writes back one map word, allocate scans the occupancy map through its
// single read port, one 64-bit word per cycle, until the first free slot or the last word
// reset clears the state and the per-word valid bits and loads the config defaults,
// so the map reads all free at once; no clearing pass; the result side cannot stall
`default_nettype none

module swap_slot_bitmap_allocator_unit #(
  parameter int MAX_SLOTS  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ssba_pkg::req_t              req_i,
  output logic                             done_o,
  output ssba_pkg::rsp_t                   rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ssba_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ssba_pkg::CFG_DW-1:0] pwdata,
  output logic      [ssba_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import ssba_pkg::*;

  localparam int SlotsUsed = (MAX_SLOTS < MAP_SLOTS) ? MAX_SLOTS : MAP_SLOTS;
  localparam int MapDepth  = (SlotsUsed + WORD_BITS - 1) / WORD_BITS;
  localparam int MapAw     = (MapDepth > 1) ? $clog2(MapDepth) : 1;

  cfg_t                 cfg;
  logic                 mem_re;
  logic [MapAw-1:0]     mem_raddr;
  logic                 mem_we;
  logic [MapAw-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  ssba_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssba_ctrl #(
    .MAX_SLOTS  (MAX_SLOTS),
    .PAGE_BYTES (PAGE_BYTES),
    .MAP_AW     (MapAw)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  ssba_map_mem #(
    .DEPTH (MapDepth),
    .AW    (MapAw)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

>>> sv/ssba_map_mem.sv
`default_nettype none

module ssba_map_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           re_i,
  input  wire logic [AW-1:0]                  raddr_i,
  input  wire logic                           we_i,
  input  wire logic [AW-1:0]                  waddr_i,
  input  wire logic [ssba_pkg::WORD_BITS-1:0] wdata_i,
  output logic      [ssba_pkg::WORD_BITS-1:0] rdata_o
);
  import ssba_pkg::*;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_word_q;
  logic                 rd_valid_q;
  logic [DEPTH-1:0]     valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_word_q <= mem_q[raddr_i];
    end
  end

  // a word never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_word_q : '0;

endmodule

`default_nettype wire

>>> sv/ssba_cfg_regs.sv
`default_nettype none

module ssba_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ssba_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ssba_pkg::CFG_DW-1:0] pwdata,
  output logic      [ssba_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output ssba_pkg::cfg_t                   cfg_o
);
  import ssba_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_SLOT_LIMIT:   cfg_d.slot_limit   = pwdata[SLOT_W-1:0];
        REG_SEARCH_START: cfg_d.search_start = pwdata[SLOT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLOT_LIMIT:   prdata = {{(CFG_DW-SLOT_W){1'b0}}, cfg_q.slot_limit};
      REG_SEARCH_START: prdata = {{(CFG_DW-SLOT_W){1'b0}}, cfg_q.search_start};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_limit   <= SLOT_LIMIT_RST;
      cfg_q.search_start <= SEARCH_START_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/ssba_ctrl.sv
`default_nettype none

module ssba_ctrl #(
  parameter int MAX_SLOTS  = 4096,
  parameter int PAGE_BYTES = 4096,
  parameter int MAP_AW     = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ssba_pkg::cfg_t                 cfg_i,
  input  wire logic                           start,
  output logic                                busy,
  input  wire ssba_pkg::req_t                 req_i,
  output logic                                done_o,
  output ssba_pkg::rsp_t                      rsp_o,
  output logic                                mem_re_o,
  output logic      [MAP_AW-1:0]              mem_raddr_o,
  output logic                                mem_we_o,
  output logic      [MAP_AW-1:0]              mem_waddr_o,
  output logic      [ssba_pkg::WORD_BITS-1:0] mem_wdata_o,
  input  wire logic [ssba_pkg::WORD_BITS-1:0] mem_rdata_i
);
  import ssba_pkg::*;

  localparam int SlotsUsed = (MAX_SLOTS < MAP_SLOTS) ? MAX_SLOTS : MAP_SLOTS;
  localparam logic [SLOT_W:0]   SlotsUsedW = (SLOT_W+1)'(SlotsUsed);
  localparam logic [OFFS_W-1:0] PageOff    = OFFS_W'(PAGE_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_FREE_WR = 4'b0100,
    ST_RESP    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [WORD_IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic                  rd_pass_q, rd_pass_d;
  logic [WORD_IDX_W:0]   rd_left_q, rd_left_d;
  logic                  chk_v_q, chk_v_d;
  logic [WORD_IDX_W-1:0] chk_addr_q, chk_addr_d;
  logic                  chk_pass_q, chk_pass_d;
  logic                  chk_last_q, chk_last_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  logic [SLOT_W:0]       lim_w;
  logic [SLOT_W-1:0]     lim;
  logic [SLOT_W-1:0]     lim_m1;
  logic [SLOT_W-1:0]     st;
  logic                  bad_id;
  logic [WORD_BITS-1:0]  allowed;
  logic [WORD_BITS-1:0]  free_bits;
  logic [BIT_IDX_W:0]    ffs;
  logic [WORD_IDX_W-1:0] raddr_w;
  logic [WORD_IDX_W-1:0] waddr_w;

  // search window derived from the registers
  assign lim_w  = ({1'b0, cfg_i.slot_limit} < SlotsUsedW) ? {1'b0, cfg_i.slot_limit} : SlotsUsedW;
  assign lim    = lim_w[SLOT_W-1:0];
  assign lim_m1 = lim - 12'd1;
  assign st     = (cfg_i.search_start == '0 || cfg_i.search_start >= lim) ? 12'd1
                                                                          : cfg_i.search_start;
  assign bad_id = ({1'b0, req_i.slot_id} >= SlotsUsedW) || (req_i.slot_id > cfg_i.slot_limit);

  // first pass covers st..lim-1, the wrapped pass covers 1..st-1
  assign allowed   = chk_pass_q ? (ge_mask(chk_addr_q, 12'd1) & ~ge_mask(chk_addr_q, st))
                                : (ge_mask(chk_addr_q, st) & ~ge_mask(chk_addr_q, lim));
  assign free_bits = allowed & ~mem_rdata_i;
  assign ffs       = first_set(free_bits);

  always_comb begin
    state_d      = state_q;
    rd_addr_d    = rd_addr_q;
    rd_pass_d    = rd_pass_q;
    rd_left_d    = rd_left_q;
    chk_v_d      = 1'b0;
    chk_addr_d   = chk_addr_q;
    chk_pass_d   = chk_pass_q;
    chk_last_d   = chk_last_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    mem_re_o     = 1'b0;
    raddr_w      = rd_addr_q;
    mem_we_o     = 1'b0;
    waddr_w      = chk_addr_q;
    mem_wdata_o  = mem_rdata_i;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (req_i.mode)
            MODE_ALLOC: begin
              if (lim < 12'd2) begin
                res_status_d = STAT_FULL;
                res_slot_d   = '0;
                state_d      = ST_RESP;
              end else begin
                rd_addr_d = st[SLOT_W-1:BIT_IDX_W];
                rd_pass_d = 1'b0;
                rd_left_d = {1'b0, lim_m1[SLOT_W-1:BIT_IDX_W]} + 7'd2;
                state_d   = ST_SCAN;
              end
            end
            MODE_FREE, MODE_LOCATE: begin
              res_slot_d = req_i.slot_id;
              if (bad_id) begin
                res_status_d = STAT_BADID;
                state_d      = ST_RESP;
              end else begin
                res_status_d = STAT_OK;
                if (req_i.mode == MODE_FREE) begin
                  mem_re_o = 1'b1;
                  raddr_w  = req_i.slot_id[SLOT_W-1:BIT_IDX_W];
                  state_d  = ST_FREE_WR;
                end else begin
                  state_d = ST_RESP;
                end
              end
            end
            default: begin
              res_status_d = STAT_BADID;
              res_slot_d   = '0;
              state_d      = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // one word read per cycle, checked when its data returns
        if (rd_left_q != '0) begin
          mem_re_o   = 1'b1;
          raddr_w    = rd_addr_q;
          rd_left_d  = rd_left_q - 7'd1;
          chk_v_d    = 1'b1;
          chk_addr_d = rd_addr_q;
          chk_pass_d = rd_pass_q;
          chk_last_d = (rd_left_q == 7'd1);
          if (!rd_pass_q && rd_addr_q == lim_m1[SLOT_W-1:BIT_IDX_W]) begin
            rd_addr_d = '0;
            rd_pass_d = 1'b1;
          end else begin
            rd_addr_d = rd_addr_q + 6'd1;
          end
        end
        if (chk_v_q) begin
          if (ffs[BIT_IDX_W]) begin
            mem_we_o     = 1'b1;
            waddr_w      = chk_addr_q;
            mem_wdata_o  = mem_rdata_i | ({{(WORD_BITS-1){1'b0}}, 1'b1} << ffs[BIT_IDX_W-1:0]);
            res_status_d = STAT_OK;
            res_slot_d   = {chk_addr_q, ffs[BIT_IDX_W-1:0]};
            chk_v_d      = 1'b0;
            state_d      = ST_RESP;
          end else if (chk_last_q) begin
            res_status_d = STAT_FULL;
            res_slot_d   = '0;
            state_d      = ST_RESP;
          end
        end
      end

      ST_FREE_WR: begin
        mem_we_o    = 1'b1;
        waddr_w     = res_slot_q[SLOT_W-1:BIT_IDX_W];
        mem_wdata_o = mem_rdata_i
                    & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << res_slot_q[BIT_IDX_W-1:0]);
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        done_d            = 1'b1;
        rsp_d.status      = res_status_q;
        rsp_d.slot        = res_slot_q;
        rsp_d.byte_offset = (res_status_q == STAT_OK) ? ({12'd0, res_slot_q} * PageOff) : '0;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_raddr_o = raddr_w[MAP_AW-1:0];
  assign mem_waddr_o = waddr_w[MAP_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_left_q <= '0;
      chk_v_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_left_q <= rd_left_d;
      chk_v_q   <= chk_v_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    rd_pass_q    <= rd_pass_d;
    chk_addr_q   <= chk_addr_d;
    chk_pass_q   <= chk_pass_d;
    chk_last_q   <= chk_last_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    rsp_q        <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

>>> sv/ssba_checker.sv
`default_nettype none

module ssba_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire ssba_pkg::rsp_t rsp_o
);
  import ssba_pkg::*;

  // an accepted word always keeps the unit busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("unit idle right after accepting a word");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without preceding work");

  // a result strobe is never high on back-to-back cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held high");

  a_err_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != STAT_OK |-> rsp_o.byte_offset == '0)
    else $error("offset reported with an error status");

  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == STAT_FULL |-> rsp_o.slot == '0)
    else $error("out of space with a nonzero slot");

endmodule

bind swap_slot_bitmap_allocator_unit ssba_checker u_ssba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
